/* hdl/scmpwm_pkg.sv */
// ----------------------------------------------------------------------------
// scmpwm_pkg: shared types and constants of the sorted-compare pwm block
// action codes, register indexes, duty limits and duty helper functions
// ----------------------------------------------------------------------------
`default_nettype none

package scmpwm_pkg;

	// channel count default and field widths
	localparam int CHANNELS_DEF = 5;
	localparam int DUTY_W       = 11;
	localparam int MAG_W        = 10;
	localparam int COUNT_W      = 16;
	localparam int GUARD_W      = 10;
	localparam int CFG_DATA_W   = 16;
	localparam int CFG_IDX_W    = 2;
	localparam int DUTY_SHIFT   = 6;

	// reset values of the registers
	localparam logic [COUNT_W-1:0] PERIOD_RST = 16'd64000;
	localparam logic [GUARD_W-1:0] GUARD_RST  = 10'd100;

	// duty clamp bounds
	localparam logic signed [DUTY_W-1:0] DUTY_MAX = 11'sd1000;
	localparam logic signed [DUTY_W-1:0] DUTY_MIN = -11'sd1000;

	typedef enum logic [1:0] {
		ACT_TICK     = 2'd0,
		ACT_SET_DUTY = 2'd1,
		ACT_SET_DIR  = 2'd2
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENABLE_MASK  = 2'd0,
		REG_PERIOD_TICKS = 2'd1,
		REG_GUARD_TICKS  = 2'd2
	} reg_idx_t;

	// limit a signed duty to plus minus one thousand
	function automatic logic signed [DUTY_W-1:0] duty_clamp(input logic signed [DUTY_W-1:0] d);
		logic signed [DUTY_W-1:0] r;
		r = d;
		if (d > DUTY_MAX) r = DUTY_MAX;
		if (d < DUTY_MIN) r = DUTY_MIN;
		return r;
	endfunction

	// magnitude of a clamped duty, fits in ten bits
	function automatic logic [MAG_W-1:0] duty_mag(input logic signed [DUTY_W-1:0] d);
		logic signed [DUTY_W-1:0] n;
		n = -d;
		return d[DUTY_W-1] ? n[MAG_W-1:0] : d[MAG_W-1:0];
	endfunction

endpackage

`default_nettype wire

/* hdl/sorted_compare_multichannel_pwm_top.sv */
// ----------------------------------------------------------------------------
// sorted_compare_multichannel_pwm_top: multichannel pwm with one moving compare
// duty writes and plain ticks load the output word from idle, a tick that hits
// the compare goes through the arm state; a wrap tick runs a selection sort, one
// channel compared per cycle, then the word; no new word until it is out
// asynchronous active-low reset: outputs low, counter 0, period 64000, guard 100
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_compare_multichannel_pwm_top #(
	parameter int CHANNELS = scmpwm_pkg::CHANNELS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// configuration write port
	input  wire logic                                cfg_write,
	input  wire logic [scmpwm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [scmpwm_pkg::CFG_DATA_W-1:0]   cfg_data,
	// input word channel
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic [1:0]                          action,
	input  wire logic [2:0]                          channel,
	input  wire logic signed [scmpwm_pkg::DUTY_W-1:0] duty_value,
	// output word channel
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic [CHANNELS-1:0]                      pwm_levels,
	output logic [CHANNELS-1:0]                      dir_levels,
	output logic [scmpwm_pkg::COUNT_W-1:0]           period_count
);

	import scmpwm_pkg::*;

	// index width into per-channel arrays, count width that can hold CHANNELS
	localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CW = $clog2(CHANNELS + 1);
	localparam logic [3:0]    CH_LIM   = 4'(CHANNELS);
	localparam logic [IW-1:0] LAST_IDX = IW'(CHANNELS - 1);
	localparam logic [CW-1:0] LAST_CNT = CW'(CHANNELS - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SORT,
		ST_ARM,
		ST_DELIVER
	} state_t;

	state_t state_q;

	// configuration registers
	logic [CHANNELS-1:0] enable_q;
	logic [COUNT_W-1:0]  period_q;
	logic [GUARD_W-1:0]  guard_q;

	// per-channel storage
	logic signed [DUTY_W-1:0] target_q [CHANNELS];
	logic [MAG_W-1:0]         snap_q   [CHANNELS];
	logic [IW-1:0]            order_q  [CHANNELS];
	logic [MAG_W-1:0]         oduty_q  [CHANNELS]; // duty of each sorted entry
	logic [CHANNELS-1:0]      used_q;

	// turn-off order walk
	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      pos_q;
	logic               armed_q;
	logic [COUNT_W-1:0] cmp_q;
	logic [COUNT_W-1:0] tick_q;
	logic [CHANNELS-1:0] pwm_q;
	logic [CHANNELS-1:0] dir_q;

	// sort scan registers
	logic [IW-1:0]    scan_q;
	logic [IW-1:0]    best_q;
	logic [MAG_W-1:0] best_val_q;
	logic             found_q;

	// output word register
	logic                out_valid_q;
	logic [CHANNELS-1:0] pwm_out_q;
	logic [CHANNELS-1:0] dir_out_q;
	logic [COUNT_W-1:0]  count_out_q;

	// ------------------------------------------------------------------
	// handshake
	// ------------------------------------------------------------------
	logic in_acc;
	logic out_free;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	// output register can take a word this cycle
	assign out_free = !out_valid_q || !out_stall;

	assign out_valid    = out_valid_q;
	assign pwm_levels   = pwm_out_q;
	assign dir_levels   = dir_out_q;
	assign period_count = count_out_q;

	// ------------------------------------------------------------------
	// item decode: next counter, levels and which follow-up step is due
	// ------------------------------------------------------------------
	logic signed [DUTY_W-1:0] duty_clamped;
	logic [COUNT_W:0]         tick_inc;
	logic                     wrap;
	logic                     hit;
	logic                     chan_ok;
	logic [IW-1:0]            pos_idx;
	logic [CHANNELS-1:0]      raise;
	logic [COUNT_W-1:0]       nxt_tick;
	logic [CHANNELS-1:0]      nxt_pwm;
	logic [CHANNELS-1:0]      nxt_dir;
	logic                     go_sort;
	logic                     go_arm;
	logic                     wr_target;

	assign duty_clamped = duty_clamp(duty_value);
	assign tick_inc     = {1'b0, tick_q} + {{COUNT_W{1'b0}}, 1'b1};
	// a period of zero makes every tick a wrap
	assign wrap         = (tick_inc >= {1'b0, period_q});
	assign pos_idx      = pos_q[IW-1:0];
	assign hit          = armed_q && (tick_inc[COUNT_W-1:0] == cmp_q) && (pos_q < cnt_q);
	assign chan_ok      = ({1'b0, channel} < CH_LIM);

	// channels raised at the wrap: enabled with nonzero duty
	always_comb begin
		for (int i = 0; i < CHANNELS; i++) begin
			raise[i] = enable_q[i] && (duty_mag(target_q[i]) != '0);
		end
	end

	always_comb begin
		nxt_tick  = tick_q;
		nxt_pwm   = pwm_q;
		nxt_dir   = dir_q;
		go_sort   = 1'b0;
		go_arm    = 1'b0;
		wr_target = 1'b0;
		unique case (action)
			ACT_TICK: begin
				if (wrap) begin
					nxt_tick = '0;
					nxt_pwm  = raise;
					go_sort  = 1'b1;
				end else begin
					nxt_tick = tick_inc[COUNT_W-1:0];
					if (hit) begin
						nxt_pwm[order_q[pos_idx]] = 1'b0;
						go_arm = 1'b1;
					end
				end
			end
			ACT_SET_DUTY: begin
				wr_target = chan_ok;
			end
			ACT_SET_DIR: begin
				wr_target = chan_ok;
				if (chan_ok) begin
					nxt_dir[channel[IW-1:0]] = (duty_clamped > 0);
				end
			end
			default: begin
				// unused action code leaves everything as it is
			end
		endcase
	end

	// output register loads a new word this cycle
	logic out_load;

	assign out_load = out_free && ((state_q == ST_IDLE && in_acc && !go_sort && !go_arm) ||
		state_q == ST_ARM || state_q == ST_DELIVER);

	// ------------------------------------------------------------------
	// shared sort comparator: one channel against the running minimum
	// strict less-than keeps the lower index on equal duty
	// ------------------------------------------------------------------
	logic [MAG_W-1:0] cur_val;
	logic             take;
	logic [IW-1:0]    new_best;
	logic [MAG_W-1:0] new_val;
	logic             new_found;
	logic             scan_last;
	logic [IW-1:0]    cnt_idx;

	assign cur_val   = snap_q[scan_q];
	assign take      = !used_q[scan_q] && (!found_q || (cur_val < best_val_q));
	assign new_best  = take ? scan_q : best_q;
	assign new_val   = take ? cur_val : best_val_q;
	assign new_found = found_q || take;
	assign scan_last = (scan_q == LAST_IDX);
	assign cnt_idx   = cnt_q[IW-1:0];

	// ------------------------------------------------------------------
	// compare arming: max of duty*64 and counter+guard (saturated)
	// ------------------------------------------------------------------
	logic [COUNT_W-1:0] arm_want;
	logic [COUNT_W:0]   arm_sum;
	logic [COUNT_W-1:0] arm_safe;
	logic [COUNT_W-1:0] arm_cmp;

	assign arm_want = {oduty_q[pos_idx], {DUTY_SHIFT{1'b0}}};
	assign arm_sum  = {1'b0, tick_q} + {{(COUNT_W + 1 - GUARD_W){1'b0}}, guard_q};
	assign arm_safe = arm_sum[COUNT_W] ? {COUNT_W{1'b1}} : arm_sum[COUNT_W-1:0];
	assign arm_cmp  = (arm_want > arm_safe) ? arm_want : arm_safe;

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= '0;
			period_q <= PERIOD_RST;
			guard_q  <= GUARD_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_ENABLE_MASK:  enable_q <= cfg_data[CHANNELS-1:0];
				REG_PERIOD_TICKS: period_q <= cfg_data[COUNT_W-1:0];
				REG_GUARD_TICKS:  guard_q  <= cfg_data[GUARD_W-1:0];
				default: begin
					// writes beyond the register list are dropped
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// sequencer with state and registered outputs
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			for (int i = 0; i < CHANNELS; i++) begin
				target_q[i] <= '0;
				snap_q[i]   <= '0;
				order_q[i]  <= '0;
				oduty_q[i]  <= '0;
			end
			used_q      <= '0;
			cnt_q       <= '0;
			pos_q       <= '0;
			armed_q     <= 1'b0;
			cmp_q       <= '0;
			tick_q      <= '0;
			pwm_q       <= '0;
			dir_q       <= '0;
			scan_q      <= '0;
			best_q      <= '0;
			best_val_q  <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
			pwm_out_q   <= '0;
			dir_out_q   <= '0;
			count_out_q <= '0;
		end else begin
			// word taken downstream and nothing new behind it
			if (out_valid_q && !out_stall && !out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						tick_q <= nxt_tick;
						pwm_q  <= nxt_pwm;
						dir_q  <= nxt_dir;
						if (wr_target) begin
							target_q[channel[IW-1:0]] <= duty_clamped;
						end
						if (go_sort) begin
							// capture enabled magnitudes, disabled channels sit out
							for (int i = 0; i < CHANNELS; i++) begin
								if (enable_q[i]) begin
									snap_q[i] <= duty_mag(target_q[i]);
								end
							end
							used_q  <= ~enable_q;
							cnt_q   <= '0;
							pos_q   <= '0;
							armed_q <= 1'b0;
							scan_q  <= '0;
							found_q <= 1'b0;
							state_q <= ST_SORT;
						end else if (go_arm) begin
							pos_q   <= pos_q + CW'(1);
							state_q <= ST_ARM;
						end else if (out_free) begin
							out_valid_q <= 1'b1;
							pwm_out_q   <= nxt_pwm;
							dir_out_q   <= nxt_dir;
							count_out_q <= nxt_tick;
						end else begin
							state_q <= ST_DELIVER;
						end
					end
				end
				ST_SORT: begin
					if (!scan_last) begin
						scan_q     <= scan_q + IW'(1);
						best_q     <= new_best;
						best_val_q <= new_val;
						found_q    <= new_found;
					end else if (new_found) begin
						// end of a pass: append the minimum to the order
						order_q[cnt_idx] <= new_best;
						oduty_q[cnt_idx] <= new_val;
						used_q[new_best] <= 1'b1;
						cnt_q            <= cnt_q + CW'(1);
						scan_q           <= '0;
						found_q          <= 1'b0;
						if (cnt_q == LAST_CNT) begin
							state_q <= ST_ARM;
						end
					end else begin
						state_q <= ST_ARM;
					end
				end
				ST_ARM: begin
					if (pos_q < cnt_q) begin
						cmp_q   <= arm_cmp;
						armed_q <= 1'b1;
					end else begin
						armed_q <= 1'b0;
					end
					if (out_free) begin
						out_valid_q <= 1'b1;
						pwm_out_q   <= pwm_q;
						dir_out_q   <= dir_q;
						count_out_q <= tick_q;
						state_q     <= ST_IDLE;
					end else begin
						state_q <= ST_DELIVER;
					end
				end
				ST_DELIVER: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						pwm_out_q   <= pwm_q;
						dir_out_q   <= dir_q;
						count_out_q <= tick_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	// the walk never runs past the sorted entries
	a_pos_in_order: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= cnt_q)
		else $error("order position beyond sorted count");

	// an armed compare always points at a sorted entry while idle
	a_armed_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(armed_q && state_q == ST_IDLE) |-> (pos_q < cnt_q))
		else $error("compare armed past the end of the order");

	// a wrapping tick clears the counter and starts the sort
	a_wrap_starts_sort: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && action == ACT_TICK && wrap) |=> (tick_q == '0 && state_q == ST_SORT))
		else $error("wrap did not reset counter and start sort");

	// the sort never lists more channels than are enabled
	a_sort_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SORT) |-> (int'(cnt_q) <= $countones(enable_q)))
		else $error("sort listed more channels than enabled");
`endif

endmodule

`default_nettype wire

/* bench/pwm_level_checker.sv */
// ----------------------------------------------------------------------------
// pwm_level_checker: scoreboard of the sorted-compare pwm block
// follows register writes and accepted input words, predicts the level word
// each one produces and compares it with the words the block hands out
// ----------------------------------------------------------------------------

module pwm_level_checker #(
	parameter int CHANNELS = scmpwm_pkg::CHANNELS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic [scmpwm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [scmpwm_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                                 in_valid,
	input  logic                                 in_stall,
	input  logic [1:0]                           action,
	input  logic [2:0]                           channel,
	input  logic signed [scmpwm_pkg::DUTY_W-1:0] duty_value,
	input  logic                                 out_valid,
	input  logic                                 out_stall,
	input  logic [CHANNELS-1:0]                  pwm_levels,
	input  logic [CHANNELS-1:0]                  dir_levels,
	input  logic [scmpwm_pkg::COUNT_W-1:0]       period_count,
	output int                                   errors,
	output int                                   expected_left
);
	import scmpwm_pkg::*;

	localparam int PRINT_CAP = 40;

	typedef struct packed {
		logic [CHANNELS-1:0] pwm;
		logic [CHANNELS-1:0] dir;
		logic [COUNT_W-1:0]  count;
	} level_word_t;

	// register copies
	logic [CHANNELS-1:0] en_mask;
	logic [COUNT_W-1:0]  period;
	logic [GUARD_W-1:0]  guard;

	// model of the pwm state
	logic signed [DUTY_W-1:0] duty_target [CHANNELS];
	logic [MAG_W-1:0]         duty_snap [CHANNELS];
	int                       off_seq [CHANNELS];
	int                       seq_pos;
	int                       seq_len;
	bit                       cmp_armed;
	logic [COUNT_W-1:0]       cmp_at;
	logic [COUNT_W-1:0]       cnt;
	logic [CHANNELS-1:0]      pwm_now;
	logic [CHANNELS-1:0]      dir_now;

	level_word_t expected_levels [$];
	int          err_n = 0;
	int          out_words;

	assign errors = err_n;

	task automatic report_mismatch(input string field, input int got, input int want);
		if (err_n < PRINT_CAP)
			$display("mismatch on word %0d: %s got %0h expected %0h", out_words, field, got, want);
		err_n++;
	endtask

	// compare point for the channel at seq_pos, or disarm past the end
	task automatic arm_next();
		int want;
		int safe;
		if (seq_pos >= seq_len) begin
			cmp_armed = 1'b0;
		end else begin
			want = int'(duty_snap[off_seq[seq_pos]]) * 64;
			safe = int'(cnt) + int'(guard);
			if (safe > 65535)
				safe = 65535;
			cmp_at = (want > safe) ? want[COUNT_W-1:0] : safe[COUNT_W-1:0];
			cmp_armed = 1'b1;
		end
	endtask

	task automatic predict_levels(input logic [1:0] act, input logic [2:0] ch,
			input logic signed [DUTY_W-1:0] raw);
		logic signed [DUTY_W-1:0] v;
		logic [CHANNELS-1:0]      taken;
		level_word_t              w;
		int                       nxt;
		int                       mag;
		int                       best;
		v = raw;
		if (v > DUTY_MAX)
			v = DUTY_MAX;
		if (v < DUTY_MIN)
			v = DUTY_MIN;
		if (act == ACT_TICK) begin
			nxt = int'(cnt) + 1;
			if (nxt >= int'(period)) begin
				// wrap: capture, raise, sort enabled channels by duty
				cnt = '0;
				pwm_now = '0;
				taken = '0;
				for (int i = 0; i < CHANNELS; i++) begin
					if (en_mask[i]) begin
						mag = int'(duty_target[i]);
						if (mag < 0)
							mag = -mag;
						duty_snap[i] = mag[MAG_W-1:0];
						if (mag != 0)
							pwm_now[i] = 1'b1;
					end else begin
						taken[i] = 1'b1;
					end
				end
				seq_len = 0;
				for (int k = 0; k < CHANNELS; k++) begin
					best = -1;
					for (int i = 0; i < CHANNELS; i++)
						if (!taken[i] && (best < 0 || duty_snap[i] < duty_snap[best]))
							best = i;
					if (best >= 0) begin
						taken[best] = 1'b1;
						off_seq[seq_len] = best;
						seq_len++;
					end
				end
				seq_pos = 0;
				arm_next();
			end else begin
				cnt = nxt[COUNT_W-1:0];
				if (cmp_armed && cnt == cmp_at && seq_pos < seq_len) begin
					pwm_now[off_seq[seq_pos]] = 1'b0;
					seq_pos++;
					arm_next();
				end
			end
		end else if ((act == ACT_SET_DUTY || act == ACT_SET_DIR) && ch < CHANNELS) begin
			duty_target[ch] = v;
			if (act == ACT_SET_DIR)
				dir_now[ch] = (v > 0);
		end
		w.pwm = pwm_now;
		w.dir = dir_now;
		w.count = cnt;
		expected_levels.push_back(w);
	endtask

	always @(posedge clk or negedge arst_n) begin
		level_word_t w;
		if (!arst_n) begin
			en_mask = '0;
			period = PERIOD_RST;
			guard = GUARD_RST;
			for (int i = 0; i < CHANNELS; i++) begin
				duty_target[i] = '0;
				duty_snap[i] = '0;
				off_seq[i] = 0;
			end
			seq_pos = 0;
			seq_len = 0;
			cmp_armed = 1'b0;
			cmp_at = '0;
			cnt = '0;
			pwm_now = '0;
			dir_now = '0;
			out_words = 0;
			expected_levels.delete();
			expected_left <= 0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_ENABLE_MASK:  en_mask = cfg_data[CHANNELS-1:0];
					REG_PERIOD_TICKS: period = cfg_data[COUNT_W-1:0];
					REG_GUARD_TICKS:  guard = cfg_data[GUARD_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				predict_levels(action, channel, duty_value);
			if (out_valid && !out_stall) begin
				if (expected_levels.size() == 0) begin
					report_mismatch("unexpected word, count", period_count, 0);
				end else begin
					w = expected_levels.pop_front();
					if (pwm_levels !== w.pwm)
						report_mismatch("pwm_levels", pwm_levels, w.pwm);
					if (dir_levels !== w.dir)
						report_mismatch("dir_levels", dir_levels, w.dir);
					if (period_count !== w.count)
						report_mismatch("period_count", period_count, w.count);
				end
				out_words++;
			end
			expected_left <= expected_levels.size();
		end
	end

endmodule

/* bench/tb_sorted_compare_multichannel_pwm_top.sv */
// ----------------------------------------------------------------------------
// tb_sorted_compare_multichannel_pwm_top: testbench of the sorted-compare pwm
// directed duty writes and ticks through two short periods, then phases of
// random words under several register settings, with random gaps and stalls;
// a separate checker predicts and compares every output word
// ----------------------------------------------------------------------------

module tb_sorted_compare_multichannel_pwm_top;
	import scmpwm_pkg::*;

	localparam int CHANNELS     = CHANNELS_DEF;
	localparam int CYCLE_LIMIT  = 1000000;
	// settling time after a drain, sized to cover the sort of a wrap word inside the block
	localparam int DRAIN_CYCLES = CHANNELS * CHANNELS + 5;
	localparam int PHASES       = 8;
	localparam int PHASE_WORDS  = 190;

	// action code the block must ignore
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]     cfg_index = '0;
	logic [CFG_DATA_W-1:0]    cfg_data = '0;
	logic                     in_valid = 1'b0;
	logic [1:0]               action = '0;
	logic [2:0]               channel = '0;
	logic signed [DUTY_W-1:0] duty_value = '0;
	logic                     out_stall = 1'b0;

	logic                     in_stall;
	logic                     out_valid;
	logic [CHANNELS-1:0]      pwm_levels;
	logic [CHANNELS-1:0]      dir_levels;
	logic [COUNT_W-1:0]       period_count;

	int          errors;
	int          expected_left;
	bit          idle_on = 1'b1;
	int          stall_left = 0;
	int unsigned cycles = 0;

	sorted_compare_multichannel_pwm_top #(.CHANNELS(CHANNELS)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.channel(channel),
		.duty_value(duty_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pwm_levels(pwm_levels),
		.dir_levels(dir_levels),
		.period_count(period_count)
	);

	pwm_level_checker #(.CHANNELS(CHANNELS)) level_chk (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.channel(channel),
		.duty_value(duty_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pwm_levels(pwm_levels),
		.dir_levels(dir_levels),
		.period_count(period_count),
		.errors(errors),
		.expected_left(expected_left)
	);

	always begin
		#6 clk = ~clk;
	end

	// run guard: a hung handshake ends the run here
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// gap length: mostly none, often short, rarely long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// receiver side: random stall bursts while idling is on
	always @(posedge clk) begin
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (idle_on && $urandom_range(0, 99) < 20) begin
			out_stall <= 1'b1;
			stall_left <= pick_gap();
		end else begin
			out_stall <= 1'b0;
		end
	end

	// one input word; valid stays high when the next word follows with no gap
	task automatic send_word(input logic [1:0] act, input logic [2:0] ch,
			input logic signed [DUTY_W-1:0] d);
		int gap;
		gap = idle_on ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		channel <= ch;
		duty_value <= d;
		do @(posedge clk); while (in_stall);
	endtask

	// stop sending, wait for every expected word, then let the block settle
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_left != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// all three registers, back to back on the write port
	task automatic load_regs(input logic [CHANNELS-1:0] mask, input logic [COUNT_W-1:0] per,
			input logic [GUARD_W-1:0] grd);
		cfg_write <= 1'b1;
		cfg_index <= REG_ENABLE_MASK;
		cfg_data <= CFG_DATA_W'(mask);
		@(posedge clk);
		cfg_index <= REG_PERIOD_TICKS;
		cfg_data <= CFG_DATA_W'(per);
		@(posedge clk);
		cfg_index <= REG_GUARD_TICKS;
		cfg_data <= CFG_DATA_W'(grd);
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	initial begin
		logic [CHANNELS-1:0]      mask;
		logic [COUNT_W-1:0]       per;
		logic [GUARD_W-1:0]       grd;
		logic [1:0]               act;
		logic [2:0]               ch;
		logic signed [DUTY_W-1:0] d;
		int                       max_mag;
		int                       dv;
		int                       r;

		// reset held low from the start, released once
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: short period, one channel disabled, compare one tick ahead
		load_regs(5'b10111, 16'd8, 10'd1);
		send_word(ACT_SET_DIR, 3'd0, DUTY_MAX);       // full positive duty
		send_word(ACT_SET_DIR, 3'd1, DUTY_MIN);       // full negative duty
		send_word(ACT_SET_DUTY, 3'd2, 11'sd1023);     // clamped down, dir kept
		send_word(ACT_SET_DIR, 3'd3, -11'sd1024);     // clamped up, disabled channel
		send_word(ACT_SET_DIR, 3'd4, 11'sd0);         // zero duty clears dir
		send_word(ACT_SET_DIR, 3'd7, 11'sd5);         // channel out of range, ignored
		send_word(ACT_UNUSED, 3'd0, 11'sd3);          // unused action, ignored
		// first wrap: compares at duty*64 lie past the period, the raised channels stay high
		for (int i = 0; i < 8; i++)
			send_word(ACT_TICK, 3'd0, 11'sd0);
		// zero duties with a tie, then ticks through to a wrap that sorts the tied channels
		send_word(ACT_SET_DUTY, 3'd0, 11'sd0);
		send_word(ACT_SET_DUTY, 3'd1, 11'sd0);
		for (int i = 0; i < 8; i++)
			send_word(ACT_TICK, 3'd0, 11'sd0);

		// random phases under different register settings
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin
					// zero period: every tick wraps
					mask = '1;
					per = '0;
					grd = '0;
				end
				1: begin
					// nothing enabled
					mask = '0;
					per = 16'd100;
					grd = 10'd3;
				end
				2: begin
					// widest period and guard
					mask = '1;
					per = 16'hFFFF;
					grd = 10'h3FF;
				end
				default: begin
					mask = ($urandom_range(0, 1) != 0) ? '1 : CHANNELS'($urandom());
					per = COUNT_W'($urandom_range(1, 900));
					r = $urandom_range(0, 9);
					if (r == 0)
						grd = '0;
					else if (r == 1)
						grd = 10'h3FF;
					else
						grd = GUARD_W'($urandom_range(0, 20));
				end
			endcase
			drain();
			load_regs(mask, per, grd);
			// keep most duties small enough for their compare to land inside the period
			max_mag = int'(per) / 64 + 2;
			for (int n = 0; n < PHASE_WORDS; n++) begin
				// some stretches run with no gaps and no stalls at all
				if (n % 50 == 0)
					idle_on <= ($urandom_range(0, 3) != 0);
				r = $urandom_range(0, 99);
				if (r < 72)
					act = ACT_TICK;
				else if (r < 84)
					act = ACT_SET_DUTY;
				else if (r < 97)
					act = ACT_SET_DIR;
				else
					act = ACT_UNUSED;
				if ($urandom_range(0, 99) < 90)
					ch = 3'($urandom_range(0, CHANNELS - 1));
				else
					ch = 3'($urandom_range(0, 7));
				r = $urandom_range(0, 99);
				if (r < 70) begin
					dv = int'($urandom_range(0, 2 * max_mag)) - max_mag;
					d = dv[DUTY_W-1:0];
				end else if (r < 85) begin
					// any 11-bit pattern, including values beyond the clamp
					d = DUTY_W'($urandom());
				end else begin
					case ($urandom_range(0, 5))
						0: d = DUTY_MAX;
						1: d = DUTY_MIN;
						2: d = 11'sd1023;
						3: d = -11'sd1024;
						4: d = 11'sd1;
						default: d = -11'sd1;
					endcase
				end
				send_word(act, ch, d);
			end
		end

		drain();
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
